// ===== hw/rtl/gcfb_pkg.sv =====
// Gripper command frame builder: shared constants, frame type and clamp helper.
// Used by gcfb_encode, gcfb_serializer and gripper_command_frame_builder.
// Depends on nothing.
package gcfb_pkg;

    localparam int FRAME_MAX = 10;
    localparam int CNT_W     = $clog2(FRAME_MAX + 1);

    localparam logic [7:0] HDR0        = 8'hEB;
    localparam logic [7:0] HDR1        = 8'h90;
    localparam logic [7:0] CMD_GRIP    = 8'h10;
    localparam logic [7:0] CMD_RELEASE = 8'h11;
    localparam logic [7:0] LEN_GRIP    = 8'h05;
    localparam logic [7:0] LEN_RELEASE = 8'h03;
    localparam logic [7:0] ID_RESET    = 8'h01;

    localparam logic [CNT_W-1:0] NBYTES_GRIP    = CNT_W'(10);
    localparam logic [CNT_W-1:0] NBYTES_RELEASE = CNT_W'(8);

    localparam logic OP_GRIP    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic signed [15:0] SPEED_MIN = 16'sd1;
    localparam logic signed [15:0] SPEED_MAX = 16'sd1000;
    localparam logic signed [15:0] FORCE_MIN = 16'sd30;
    localparam logic signed [15:0] FORCE_MAX = 16'sd1000;

    typedef logic [FRAME_MAX-1:0][7:0] frame_bytes_t;

    typedef struct packed {
        frame_bytes_t     bytes;   // bytes[0] goes out first
        logic [CNT_W-1:0] nbytes;
    } frame_t;

    // Clamp a signed request into [lo, hi]; the result always fits 16 bits unsigned.
    function automatic logic [15:0] clamp16(input logic signed [15:0] v,
                                            input logic signed [15:0] lo,
                                            input logic signed [15:0] hi);
        logic signed [15:0] r;
        begin
            r = v;
            if (r < lo)
            begin
                r = lo;
            end
            if (r > hi)
            begin
                r = hi;
            end
            return 16'(r);
        end
    endfunction

endpackage

// ===== hw/rtl/gripper_command_frame_builder.sv =====
// Top level of the gripper command frame builder: device id register,
// command register with frame assembly, and byte serializer.
// Depends on gcfb_pkg, gcfb_encode and gcfb_serializer.
//
// Channel   | Ports                                        | Transfer when
// ----------+----------------------------------------------+---------------------------
// command   | start, busy, opcode, speed_request,          | start && !busy
//           | force_request                                |
// frame out | byte_strobe, frame_byte, last_byte           | byte_strobe (one cycle)
// config    | cfg_valid, cfg_ready, cfg_data (device id)   | cfg_valid && cfg_ready
//
// A grip frame is 10 bytes on the output, a release frame 8; one byte per
// cycle is the limit set by the single output byte lane. The first byte leaves
// after the command is registered and then loaded into the serializer. Frames
// follow each other with no gap: the next command sits in the command register
// and loads on the last byte. busy rises only while a command waits for the
// serializer. Reset clears the command slot and the serializer and sets device
// id to 1. The receiver cannot stall; every byte shows for exactly one cycle.
module gripper_command_frame_builder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic signed [15:0] speed_request,
    input  logic signed [15:0] force_request,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    output logic               byte_strobe,
    output logic [7:0]         frame_byte,
    output logic               last_byte
);
    import gcfb_pkg::*;

    logic [7:0] device_id_reg;
    logic       accept;
    logic       take;
    logic       cmd_valid;
    logic       ser_free;
    frame_t     frame;

    // Device id: writable at any time, used when a frame is assembled.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg <= ID_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            device_id_reg <= cfg_data;
        end
    end

    // Hand the waiting command to the serializer when it is idle or on its
    // last byte; the command slot then frees up in the same cycle.
    assign take   = cmd_valid && ser_free;
    assign busy   = cmd_valid && !ser_free;
    assign accept = start && !busy;

    gcfb_encode u_encode (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .take          (take),
        .opcode        (opcode),
        .speed_request (speed_request),
        .force_request (force_request),
        .device_id     (device_id_reg),
        .cmd_valid     (cmd_valid),
        .frame         (frame)
    );

    gcfb_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take),
        .frame       (frame),
        .free        (ser_free),
        .byte_strobe (byte_strobe),
        .frame_byte  (frame_byte),
        .last_byte   (last_byte)
    );

    // A frame never breaks off before its checksum byte.
    a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        byte_strobe && !last_byte |=> byte_strobe)
        else $error("frame interrupted before last byte");

    // The end marker only appears on a shown byte.
    a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_byte |-> byte_strobe)
        else $error("last_byte without byte_strobe");

    // A command taken with everything idle starts its frame with the header.
    a_header_first: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cmd_valid && !byte_strobe |=> ##1 (byte_strobe && frame_byte == HDR0))
        else $error("frame did not start with header byte");

    // A waiting command is never dropped while the serializer is busy.
    a_hold_command: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> cmd_valid)
        else $error("pending command lost");

endmodule

// ===== hw/rtl/gcfb_encode.sv =====
// Command register and frame assembly: clamp, lay out the bytes, checksum.
// Depends on gcfb_pkg.
module gcfb_encode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 take,
    input  logic                 opcode,
    input  logic signed [15:0]   speed_request,
    input  logic signed [15:0]   force_request,
    input  logic [7:0]           device_id,
    output logic                 cmd_valid,
    output gcfb_pkg::frame_t     frame
);
    import gcfb_pkg::*;

    logic               valid_reg, valid_next;
    logic               op_reg;
    logic signed [15:0] speed_reg;
    logic signed [15:0] force_reg;

    logic [15:0] speed_c;
    logic [15:0] force_c;
    logic [7:0]  len_b;
    logic [7:0]  cmd_b;
    logic [7:0]  sum_b;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode;
            speed_reg <= speed_request;
            force_reg <= force_request;
        end
    end

    assign cmd_valid = valid_reg;

    always_comb
    begin
        speed_c = clamp16(speed_reg, SPEED_MIN, SPEED_MAX);
        force_c = clamp16(force_reg, FORCE_MIN, FORCE_MAX);
        frame   = '0;
        if (op_reg == OP_RELEASE)
        begin
            len_b = LEN_RELEASE;
            cmd_b = CMD_RELEASE;
            sum_b = device_id + len_b + cmd_b + speed_c[7:0] + speed_c[15:8];
            frame.bytes[7] = sum_b;
            frame.nbytes   = NBYTES_RELEASE;
        end
        else
        begin
            len_b = LEN_GRIP;
            cmd_b = CMD_GRIP;
            sum_b = device_id + len_b + cmd_b + speed_c[7:0] + speed_c[15:8]
                  + force_c[7:0] + force_c[15:8];
            frame.bytes[7] = force_c[7:0];
            frame.bytes[8] = force_c[15:8];
            frame.bytes[9] = sum_b;
            frame.nbytes   = NBYTES_GRIP;
        end
        frame.bytes[0] = HDR0;
        frame.bytes[1] = HDR1;
        frame.bytes[2] = device_id;
        frame.bytes[3] = len_b;
        frame.bytes[4] = cmd_b;
        frame.bytes[5] = speed_c[7:0];
        frame.bytes[6] = speed_c[15:8];
    end

endmodule

// ===== hw/rtl/gcfb_serializer.sv =====
// Byte serializer: holds one assembled frame and shifts it out a byte per cycle.
// Depends on gcfb_pkg.
module gcfb_serializer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  gcfb_pkg::frame_t     frame,
    output logic                 free,
    output logic                 byte_strobe,
    output logic [7:0]           frame_byte,
    output logic                 last_byte
);
    import gcfb_pkg::*;

    frame_bytes_t     shift_reg, shift_next;
    logic [CNT_W-1:0] left_reg, left_next;

    always_comb
    begin
        shift_next = shift_reg;
        left_next  = left_reg;
        if (load)
        begin
            shift_next = frame.bytes;
            left_next  = frame.nbytes;
        end
        else if (left_reg != '0)
        begin
            shift_next = shift_reg >> 8;
            left_next  = left_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign byte_strobe = (left_reg != '0);
    assign last_byte   = (left_reg == CNT_W'(1));
    assign free        = (left_reg == '0) || (left_reg == CNT_W'(1));
    assign frame_byte  = shift_reg[0];

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for gripper_command_frame_builder: drives grip and release commands,
// rewrites the device id between phases and checks every frame byte in a scoreboard class.
// Depends on gcfb_pkg and the gripper_command_frame_builder RTL.
import gcfb_pkg::*;

class frame_scoreboard;
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_beat_t;

    logic [7:0]  device_id;
    frame_beat_t beats_due[$];
    int          mismatches;
    int          beats_checked;
    int          grips;
    int          releases;

    function new();
        device_id     = ID_RESET;
        mismatches    = 0;
        beats_checked = 0;
        grips         = 0;
        releases      = 0;
    endfunction

    function logic [15:0] bound_request(logic signed [15:0] req, int lo, int hi);
        int v;
        v = req;
        v = (v < lo) ? lo : v;
        v = (v > hi) ? hi : v;
        return v[15:0];
    endfunction

    // Build the whole frame for one accepted command and queue its bytes
    function void note_command(logic op, logic signed [15:0] spd, logic signed [15:0] frc);
        logic [7:0]  frame [FRAME_MAX];
        logic [15:0] speed_val;
        logic [15:0] grip_strength;
        logic [7:0]  sum;
        int          n;
        frame_beat_t beat;
        speed_val     = bound_request(spd, SPEED_MIN, SPEED_MAX);
        grip_strength = bound_request(frc, FORCE_MIN, FORCE_MAX);
        frame[0] = HDR0;
        frame[1] = HDR1;
        frame[2] = device_id;
        frame[5] = speed_val[7:0];
        frame[6] = speed_val[15:8];
        if (op == OP_RELEASE)
        begin
            frame[3] = LEN_RELEASE;
            frame[4] = CMD_RELEASE;
            n = 7;
            releases++;
        end
        else
        begin
            frame[3] = LEN_GRIP;
            frame[4] = CMD_GRIP;
            frame[7] = grip_strength[7:0];
            frame[8] = grip_strength[15:8];
            n = 9;
            grips++;
        end
        sum = 8'h00;
        for (int i = 2; i < n; i++)
        begin
            sum = sum + frame[i];
        end
        frame[n] = sum;
        n++;
        for (int i = 0; i < n; i++)
        begin
            beat.value = frame[i];
            beat.last  = (i == n - 1);
            beats_due.push_back(beat);
        end
    endfunction

    task report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task check_byte(logic [7:0] value, logic last);
        frame_beat_t due;
        if (beats_due.size() == 0)
        begin
            report_mismatch($sformatf("byte %02h last=%0b with nothing expected", value, last));
        end
        else
        begin
            due = beats_due.pop_front();
            if (value !== due.value)
            begin
                report_mismatch($sformatf("beat %0d frame_byte %02h, want %02h",
                                          beats_checked, value, due.value));
            end
            if (last !== due.last)
            begin
                report_mismatch($sformatf("beat %0d last_byte %0b, want %0b",
                                          beats_checked, last, due.last));
            end
            beats_checked++;
        end
    endtask
endclass

module tb_top;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 72;
    localparam int TAIL_CYCLES      = 24;
    localparam int GAP_MAX          = 40;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               start         = 1'b0;
    logic               busy;
    logic               opcode        = 1'b0;
    logic signed [15:0] speed_request = 16'sd0;
    logic signed [15:0] force_request = 16'sd0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_data      = 8'h00;
    logic               byte_strobe;
    logic [7:0]         frame_byte;
    logic               last_byte;

    frame_scoreboard sb;
    int              cycles      = 0;
    int              id_settings = 1;

    always #4 clk = ~clk;

    gripper_command_frame_builder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .speed_request (speed_request),
        .force_request (force_request),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .byte_strobe   (byte_strobe),
        .frame_byte    (frame_byte),
        .last_byte     (last_byte)
    );

    // Check each frame byte in the cycle it shows; the receiver never stalls,
    // so the strobe sampled at the edge marks exactly one transfer.
    always @(posedge clk)
    begin
        if (rst_n && byte_strobe)
        begin
            sb.check_byte(frame_byte, last_byte);
        end
    end

    // Watchdog: end the run if the block hangs or drops bytes.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Present one command and hold it until the transfer (start && !busy).
    // Drop start only when an idle gap follows, so a back-to-back command
    // keeps start high with a single assignment per edge.
    task automatic send_command(logic op, logic [15:0] spd, logic [15:0] frc, int idle_pct);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
            begin
                // scramble the fields while start is low; the block must ignore them
                opcode        <= 1'($urandom);
                speed_request <= 16'($urandom);
                force_request <= 16'($urandom);
                @(posedge clk);
            end
        end
        start         <= 1'b1;
        opcode        <= op;
        speed_request <= spd;
        force_request <= frc;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_command(op, spd, frc);
    endtask

    // Mix of full-range noise, in-range values and values around both limits
    function automatic logic [15:0] pick_request(int lo, int hi);
        int v;
        case ($urandom_range(3))
            0:       v = $urandom_range(65535);
            1:       v = $urandom_range(hi, lo);
            2:       v = lo - 2 + $urandom_range(4);
            default: v = hi - 2 + $urandom_range(4);
        endcase
        return v[15:0];
    endfunction

    // Write the device id only once every queued byte is out
    task automatic write_device_id(logic [7:0] value);
        while (sb.beats_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.device_id = value;
        id_settings++;
    endtask

    task automatic run_random(int idle_pct, int count);
        logic op;
        for (int k = 0; k < count; k++)
        begin
            op = ($urandom_range(1) == 1) ? OP_RELEASE : OP_GRIP;
            send_command(op, pick_request(SPEED_MIN, SPEED_MAX),
                         pick_request(FORCE_MIN, FORCE_MAX), idle_pct);
        end
        start <= 1'b0;
    endtask

    initial
    begin
        logic [7:0] phase_ids [4];
        int         phase_idle [4];
        sb = new();
        phase_ids  = '{8'hFF, 8'h00, 8'($urandom), 8'h5A};
        phase_idle = '{0, 70, 14, 0};

        // Hold reset low, then release it once
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed commands under the reset device id: field extremes,
        // clamp limits on both sides, and release frames with force ignored
        send_command(OP_GRIP,    16'h8000, 16'h8000, 0);
        send_command(OP_GRIP,    16'h7FFF, 16'h7FFF, 0);
        send_command(OP_GRIP,    16'd0,    16'd29,   0);
        send_command(OP_GRIP,    16'd1,    16'd30,   0);
        send_command(OP_GRIP,    16'd2,    16'd31,   0);
        send_command(OP_GRIP,    16'd999,  16'd999,  0);
        send_command(OP_GRIP,    16'd1000, 16'd1000, 0);
        send_command(OP_GRIP,    16'd1001, 16'd1001, 0);
        send_command(OP_GRIP,    16'hFFFF, 16'hFFFF, 0);
        send_command(OP_GRIP,    16'h5555, 16'h2AAA, 0);
        send_command(OP_GRIP,    16'd500,  16'd500,  0);
        send_command(OP_RELEASE, 16'h8000, 16'h7FFF, 0);
        send_command(OP_RELEASE, 16'h7FFF, 16'h8000, 0);
        send_command(OP_RELEASE, 16'd0,    16'd0,    0);
        send_command(OP_RELEASE, 16'd1,    16'd5,    0);
        send_command(OP_RELEASE, 16'd1000, 16'd1000, 0);
        send_command(OP_RELEASE, 16'd1001, 16'd29,   0);
        send_command(OP_RELEASE, 16'hFFFF, 16'hFFFF, 0);
        send_command(OP_RELEASE, 16'd300,  16'h7FFF, 0);
        send_command(OP_RELEASE, 16'd300,  16'h8000, 0);
        start <= 1'b0;

        // Random phases, each under a new device id and sender idling rate
        for (int p = 0; p < 4; p++)
        begin
            write_device_id(phase_ids[p]);
            run_random(phase_idle[p], RANDOM_PER_PHASE);
        end

        // Drain: wait for the last frame, then allow stray bytes to show
        while (sb.beats_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d grip and %0d release commands under %0d device id values,",
                 sb.grips, sb.releases, id_settings);
        $display("with %0d frame bytes checked and %0d mismatches.",
                 sb.beats_checked, sb.mismatches);
        if (sb.mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
